### sv/rgbf_pkg.sv
// shared types and constants for the rgb pwm color fader
// no dependencies
package rgbf_pkg;

  localparam int unsigned TickW            = 16;
  localparam int unsigned DutyW            = 9;
  localparam int unsigned DefaultAmplitude = 500;

  localparam logic [TickW-1:0] PeriodReset = 16'd1000;

  typedef struct packed {
    logic [DutyW-1:0] red;
    logic [DutyW-1:0] green;
    logic [DutyW-1:0] blue;
  } rgbf_duty_t;

  typedef struct packed {
    logic             red_on;
    logic             green_on;
    logic             blue_on;
    logic [DutyW-1:0] red_level;
    logic [DutyW-1:0] green_level;
    logic [DutyW-1:0] blue_level;
    logic             period_wrap;
  } rgbf_result_t;

endpackage

### sv/rgb_pwm_color_fader_core.sv
// top level of the three-channel rgb pwm with color wheel crossfade
// depends on rgbf_pkg, rgbf_step, rgbf_out_reg
// Each accepted input beat is one timer tick. A beat is held in the input register, its counter,
// crossfade and compare work is done in combinational logic, and its result lands in the output
// register, so a beat passes the input register and then the output register on its way to the
// outputs, and one beat per cycle is sustained while the output is not stalled.
// Writes to period_q take effect on the next advancing tick; one period is
// period_q + 1 advancing ticks, and the three duties always sum to Amplitude.
module rgb_pwm_color_fader_core import rgbf_pkg::*; #(
  parameter int unsigned Amplitude = DefaultAmplitude
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [TickW-1:0] cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             advance_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic             red_on_o,
  output logic             green_on_o,
  output logic             blue_on_o,
  output logic [DutyW-1:0] red_level_o,
  output logic [DutyW-1:0] green_level_o,
  output logic [DutyW-1:0] blue_level_o,
  output logic             period_wrap_o
);

  logic             in_valid_q;
  logic             advance_q;
  logic [TickW-1:0] period_q;
  logic [TickW-1:0] tick_q, tick_d;
  rgbf_duty_t       duty_q, duty_d;
  rgbf_result_t     step_result, out_result;
  logic             out_ready;
  logic             step_go;
  logic             in_take;

  assign step_go    = in_valid_q && out_ready;
  assign in_stall_o = in_valid_q && !out_ready;
  assign in_take    = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      advance_q <= advance_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  rgbf_step #(
    .Amplitude (Amplitude)
  ) u_step (
    .tick_i    (tick_q),
    .period_i  (period_q),
    .duty_i    (duty_q),
    .advance_i (advance_q),
    .tick_o    (tick_d),
    .duty_o    (duty_d),
    .result_o  (step_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q       <= '0;
      duty_q.red   <= DutyW'(Amplitude);
      duty_q.green <= '0;
      duty_q.blue  <= '0;
    end else if (step_go) begin
      tick_q <= tick_d;
      duty_q <= duty_d;
    end
  end

  rgbf_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step_go),
    .result_i    (step_result),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (out_result)
  );

  assign red_on_o      = out_result.red_on;
  assign green_on_o    = out_result.green_on;
  assign blue_on_o     = out_result.blue_on;
  assign red_level_o   = out_result.red_level;
  assign green_level_o = out_result.green_level;
  assign blue_level_o  = out_result.blue_level;
  assign period_wrap_o = out_result.period_wrap;

endmodule

### sv/rgbf_step.sv
// one tick of counter, crossfade step and compare logic
// depends on rgbf_pkg
module rgbf_step import rgbf_pkg::*; #(
  parameter int unsigned Amplitude = DefaultAmplitude
) (
  input  logic [TickW-1:0] tick_i,
  input  logic [TickW-1:0] period_i,
  input  rgbf_duty_t       duty_i,
  input  logic             advance_i,
  output logic [TickW-1:0] tick_o,
  output rgbf_duty_t       duty_o,
  output rgbf_result_t     result_o
);

  localparam logic [DutyW-1:0] FadeTop = DutyW'(Amplitude - 1);
  localparam logic [DutyW-1:0] DutyOne = DutyW'(1);
  localparam logic [DutyW-1:0] DutyTwo = DutyW'(2);

  logic       wrap;
  rgbf_duty_t faded;

  always_comb begin
    faded = duty_i;
    if (duty_i.red > DutyOne && duty_i.blue < DutyTwo && duty_i.green < FadeTop) begin
      faded.green = duty_i.green + DutyOne;
      faded.red   = duty_i.red - DutyOne;
    end else if (duty_i.green > DutyOne && duty_i.red < DutyTwo &&
                 duty_i.blue < FadeTop) begin
      faded.blue  = duty_i.blue + DutyOne;
      faded.green = duty_i.green - DutyOne;
    end else if (duty_i.blue > DutyOne && duty_i.green < DutyTwo &&
                 duty_i.red < FadeTop) begin
      faded.red   = duty_i.red + DutyOne;
      faded.blue  = duty_i.blue - DutyOne;
    end
  end

  always_comb begin
    wrap   = 1'b0;
    tick_o = tick_i;
    duty_o = duty_i;
    if (advance_i) begin
      if (tick_i >= period_i) begin
        wrap   = 1'b1;
        tick_o = '0;
        duty_o = faded;
      end else begin
        tick_o = tick_i + TickW'(1);
      end
    end
  end

  always_comb begin
    result_o.red_on      = tick_o < {{(TickW-DutyW){1'b0}}, duty_o.red};
    result_o.green_on    = tick_o < {{(TickW-DutyW){1'b0}}, duty_o.green};
    result_o.blue_on     = tick_o < {{(TickW-DutyW){1'b0}}, duty_o.blue};
    result_o.red_level   = duty_o.red;
    result_o.green_level = duty_o.green;
    result_o.blue_level  = duty_o.blue;
    result_o.period_wrap = wrap;
  end

endmodule

### sv/rgbf_out_reg.sv
// result register with valid/stall handshake toward the consumer
// depends on rgbf_pkg
module rgbf_out_reg import rgbf_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  rgbf_result_t result_i,
  output logic         ready_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output rgbf_result_t result_o
);

  logic         valid_q, valid_d;
  rgbf_result_t result_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      result_q <= result_i;
    end
  end

  assign out_valid_o = valid_q;
  assign result_o    = result_q;

endmodule

### sv/rgbf_checker.sv
// port-level checks for rgb_pwm_color_fader_core, bound to the top level
// depends on rgbf_pkg and rgb_pwm_color_fader_core
module rgbf_checker import rgbf_pkg::*; #(
  parameter int unsigned Amplitude = DefaultAmplitude
) (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input logic             red_on_o,
  input logic             green_on_o,
  input logic             blue_on_o,
  input logic [DutyW-1:0] red_level_o,
  input logic [DutyW-1:0] green_level_o,
  input logic [DutyW-1:0] blue_level_o,
  input logic             period_wrap_o
);

  localparam int unsigned SumW = DutyW + 2;

  logic [SumW-1:0] level_sum;

  assign level_sum = SumW'(red_level_o) + SumW'(green_level_o) + SumW'(blue_level_o);

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(red_level_o) &&
      $stable(green_level_o) && $stable(blue_level_o) && $stable(period_wrap_o))
    else $error("stalled beat changed");

  // crossfade keeps total brightness
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> level_sum == SumW'(Amplitude))
    else $error("duty sum differs from amplitude");

  // zero duty drives low
  a_zero_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_level_o != '0 || !red_on_o) &&
      (green_level_o != '0 || !green_on_o) && (blue_level_o != '0 || !blue_on_o))
    else $error("zero duty channel driven high");

  // count restarts at zero on a wrap, so every nonzero duty is on
  a_wrap_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && period_wrap_o |-> (red_on_o == (red_level_o != '0)) &&
      (green_on_o == (green_level_o != '0)) && (blue_on_o == (blue_level_o != '0)))
    else $error("drive mismatch at period wrap");

endmodule

bind rgb_pwm_color_fader_core rgbf_checker #(
  .Amplitude (Amplitude)
) u_rgbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .red_on_o      (red_on_o),
  .green_on_o    (green_on_o),
  .blue_on_o     (blue_on_o),
  .red_level_o   (red_level_o),
  .green_level_o (green_level_o),
  .blue_level_o  (blue_level_o),
  .period_wrap_o (period_wrap_o)
);

### tb/tb_rgb_pwm_color_fader_core.sv
// self-checking testbench for rgb_pwm_color_fader_core: tick beats in, drive beats out
// a tracker class predicts the pwm counter and crossfade and checks each output beat
// depends on rgbf_pkg and rgb_pwm_color_fader_core
module tb_rgb_pwm_color_fader_core;
  import rgbf_pkg::*;

  localparam int unsigned CycleLimit = 400000;

  class pwm_fade_tracker;
    logic [TickW-1:0] period;
    logic [TickW-1:0] tick;
    rgbf_duty_t       duty;
    rgbf_result_t     pending_drive[$];
    int unsigned      mismatches;

    function new();
      period     = PeriodReset;
      tick       = '0;
      duty.red   = DutyW'(DefaultAmplitude);
      duty.green = '0;
      duty.blue  = '0;
      mismatches = 0;
    endfunction

    function void set_period(logic [TickW-1:0] value);
      period = value;
    endfunction

    function void step_fade();
      int unsigned top;
      top = DefaultAmplitude - 1;
      if (duty.red > 1 && duty.blue < 2 && duty.green < top) begin
        duty.green = duty.green + 1'b1;
        duty.red   = duty.red - 1'b1;
      end else if (duty.green > 1 && duty.red < 2 && duty.blue < top) begin
        duty.blue  = duty.blue + 1'b1;
        duty.green = duty.green - 1'b1;
      end else if (duty.blue > 1 && duty.green < 2 && duty.red < top) begin
        duty.red  = duty.red + 1'b1;
        duty.blue = duty.blue - 1'b1;
      end
    endfunction

    function void note_tick(logic advance);
      rgbf_result_t drive;
      drive.period_wrap = 1'b0;
      if (advance) begin
        if (tick >= period) begin
          tick = '0;
          step_fade();
          drive.period_wrap = 1'b1;
        end else begin
          tick = tick + 1'b1;
        end
      end
      drive.red_on      = (tick < duty.red);
      drive.green_on    = (tick < duty.green);
      drive.blue_on     = (tick < duty.blue);
      drive.red_level   = duty.red;
      drive.green_level = duty.green;
      drive.blue_level  = duty.blue;
      pending_drive.push_back(drive);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, actual %0d", field, want, got);
        mismatches++;
      end
    endfunction

    function void check_drive(rgbf_result_t got);
      rgbf_result_t want;
      if (pending_drive.size() == 0) begin
        $error("output beat with no expected drive pending");
        mismatches++;
        return;
      end
      want = pending_drive.pop_front();
      compare_field("red_on", 16'(want.red_on), 16'(got.red_on));
      compare_field("green_on", 16'(want.green_on), 16'(got.green_on));
      compare_field("blue_on", 16'(want.blue_on), 16'(got.blue_on));
      compare_field("red_level", 16'(want.red_level), 16'(got.red_level));
      compare_field("green_level", 16'(want.green_level), 16'(got.green_level));
      compare_field("blue_level", 16'(want.blue_level), 16'(got.blue_level));
      compare_field("period_wrap", 16'(want.period_wrap), 16'(got.period_wrap));
    endfunction
  endclass

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [TickW-1:0] cfg_data_i = '0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic             advance_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             red_on_o;
  logic             green_on_o;
  logic             blue_on_o;
  logic [DutyW-1:0] red_level_o;
  logic [DutyW-1:0] green_level_o;
  logic [DutyW-1:0] blue_level_o;
  logic             period_wrap_o;

  rgbf_result_t     seen;
  int unsigned      cycle_count = 0;
  int unsigned      stall_left = 0;
  logic [1:0]       stall_mode = 2'd0;

  pwm_fade_tracker  tracker = new();

  rgb_pwm_color_fader_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .advance_i    (advance_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .red_on_o     (red_on_o),
    .green_on_o   (green_on_o),
    .blue_on_o    (blue_on_o),
    .red_level_o  (red_level_o),
    .green_level_o(green_level_o),
    .blue_level_o (blue_level_o),
    .period_wrap_o(period_wrap_o)
  );

  assign seen = {red_on_o, green_on_o, blue_on_o, red_level_o, green_level_o, blue_level_o,
                 period_wrap_o};

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver stall pattern, switching mode every so often
  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_mode <= 2'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      2'd0: out_stall_i <= 1'b0;
      2'd1: out_stall_i <= ($urandom_range(0, 3) == 0);
      2'd2: out_stall_i <= ($urandom_range(0, 9) < 7);
      default: out_stall_i <= (cycle_count[2:0] < 3'd3);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      tracker.check_drive(seen);
    end
  end

  task automatic send_beat(logic adv);
    in_valid_i <= 1'b1;
    advance_i  <= adv;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    tracker.note_tick(adv);
  endtask

  // back-to-back beats, advance bits taken lsb first
  task automatic drive_pattern(logic [15:0] pattern, int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      send_beat(pattern[i]);
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic send_ticks(int unsigned count, int unsigned adv_pct);
    int unsigned done;
    int unsigned burst;
    done = 0;
    while (done < count) begin
      burst = $urandom_range(1, 48);
      while (burst > 0 && done < count) begin
        send_beat($urandom_range(0, 99) < adv_pct);
        done++;
        burst--;
      end
      if (done < count && $urandom_range(0, 3) != 0) begin
        in_valid_i <= 1'b0;
        advance_i  <= 1'($urandom_range(0, 1));
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b0;
  endtask

  task automatic write_period(logic [TickW-1:0] value);
    while (tracker.pending_drive.size() != 0) @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_period(value);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset period, holds mixed with advances
    drive_pattern(16'b10110, 5);
    // zero period wraps on every advancing tick
    write_period('0);
    drive_pattern(16'b1011, 4);
    write_period(16'hFFFF);
    drive_pattern(16'h003F, 6);
    // period lowered below the count wraps on the next advance
    write_period(16'd2);
    drive_pattern(16'b101, 3);
    write_period(16'd1);
    drive_pattern(16'b111, 3);

    // long run at zero period walks the fade through all three legs
    write_period('0);
    send_ticks(1100, 95);
    write_period(16'hFFFF);
    send_ticks(60, 70);
    write_period(16'd5);
    send_ticks(40, 80);
    write_period(16'd1);
    send_ticks(80, 80);
    write_period(16'd7);
    send_ticks(90, 60);
    write_period(TickW'($urandom_range(2, 40)));
    send_ticks(100, 85);
    write_period(16'd600);
    send_ticks(120, 90);
    write_period(PeriodReset);
    send_ticks(60, 50);

    while (tracker.pending_drive.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
